// ===== design/heading_align_controller_defines.svh =====
// Assertion helpers shared by the heading alignment RTL
`ifndef HEADING_ALIGN_CONTROLLER_DEFINES_SVH
`define HEADING_ALIGN_CONTROLLER_DEFINES_SVH

// property that holds whenever the block is out of reset
`define HAC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on the following cycle
`define HAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hac_pkg.sv =====
`timescale 1ns / 1ps
package hac_pkg;
   localparam logic [1:0] CMD_RESET_ALIGN = 2'd0;
   localparam logic [1:0] CMD_CLEAR_ROUTE = 2'd1;
   localparam logic [1:0] CMD_APPEND      = 2'd2;
   localparam logic [1:0] CMD_TICK        = 2'd3;

   localparam logic [2:0] ST_ALIGNING  = 3'd0;
   localparam logic [2:0] ST_ALIGNED   = 3'd1;
   localparam logic [2:0] ST_WAITING   = 3'd2;
   localparam logic [2:0] ST_TIMED_OUT = 3'd3;
   localparam logic [2:0] ST_BAD_TASK  = 3'd4;
   localparam logic [2:0] ST_BAD_CFG   = 3'd5;
   localparam logic [2:0] ST_STORED    = 3'd6;
   localparam logic [2:0] ST_FULL      = 3'd7;

   localparam logic [2:0] REG_ENTER = 3'd0;
   localparam logic [2:0] REG_EXIT  = 3'd1;
   localparam logic [2:0] REG_HOLD  = 3'd2;
   localparam logic [2:0] REG_GAIN  = 3'd3;
   localparam logic [2:0] REG_RATE  = 3'd4;
   localparam logic [2:0] REG_MIND  = 3'd5;

   localparam int ATAN_LEN = 24;

   // atan(2^-i) in 2^32 = 2*pi units
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0: r = 32'd536870912;
         5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;
         5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;
         5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;
         5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;
         5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic        start;
      logic [32:0] dx;
      logic [32:0] dy;
   } cordic_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] angle;
   } cordic_rsp_type;
endpackage

// ===== design/heading_align_controller.sv =====
`timescale 1ns / 1ps
`include "heading_align_controller_defines.svh"
// Channel  | Ports | Contents
// request  | req_* | tdata {now_ms, heading, pos_y, pos_x}, tuser {flag, command}
// response | rsp_* | tdata {stamp_ms, tgt_valid, heading_error, target_heading, turn_cmd}
//          |       | tuser status
// config   | csr_* | write enable, index, 32-bit data
// Store and clear commands go from dispatch straight to the response; a tick with a known
// target goes straight to the control step. Resolving a target reads route points over up
// to three passes, checks each candidate length coarsely, falls back to squares on the shared
// multiplier when that check fails, and makes at most one CORDIC run.
// req_tready is low from acceptance until the response beat leaves.
// Synchronous reset clears control state; route memory needs no clearing.
module heading_align_controller
   import hac_pkg::*;
#(
   parameter int MAX_POINTS   = 64,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // pos_x[31:0], pos_y[63:32], heading[79:64], now_ms[111:80]
   input  logic [2:0]   req_tuser,  // command[1:0], flag[2]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,  // turn_cmd[15:0], target_heading[31:16],
                                    // heading_error[47:32], tgt_valid[48], stamp_ms[80:49]
   output logic [2:0]   rsp_tuser,  // status
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_RD     = 4'd2;  // issue memory read
   localparam logic [3:0] S_LAT    = 4'd3;  // capture read data
   localparam logic [3:0] S_CHK    = 4'd4;  // coarse far check
   localparam logic [3:0] S_SQX    = 4'd5;
   localparam logic [3:0] S_SQY    = 4'd6;
   localparam logic [3:0] S_SQC    = 4'd7;
   localparam logic [3:0] S_CORD   = 4'd8;
   localparam logic [3:0] S_CWAIT  = 4'd9;
   localparam logic [3:0] S_CTRL   = 4'd10;
   localparam logic [3:0] S_MUL    = 4'd11;
   localparam logic [3:0] S_FIN    = 4'd12;
   localparam logic [3:0] S_OUT    = 4'd13;

   localparam logic [1:0] P_SEG = 2'd0;
   localparam logic [1:0] P_HDG = 2'd1;
   localparam logic [1:0] P_ROB = 2'd2;

   logic [15:0] enter_ff, exit_ff, gain_ff;
   logic [31:0] hold_ff;
   logic [14:0] rlim_ff;
   logic [30:0] mind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enter_ff <= 16'd910;
         exit_ff  <= 16'd364;
         hold_ff  <= 32'd5000;
         gain_ff  <= 16'd512;
         rlim_ff  <= 15'd4096;
         mind_ff  <= 31'd100;
      end else if (csr_we) begin
         case (csr_index)
            REG_ENTER: enter_ff <= csr_wdata[15:0];
            REG_EXIT:  exit_ff  <= csr_wdata[15:0];
            REG_HOLD:  hold_ff  <= csr_wdata;
            REG_GAIN:  gain_ff  <= csr_wdata[15:0];
            REG_RATE:  rlim_ff  <= csr_wdata[14:0];
            REG_MIND:  mind_ff  <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // route memory, x/y/heading with valid bit
   logic [31:0] mem_x [MAX_POINTS];
   logic [31:0] mem_y [MAX_POINTS];
   logic [16:0] mem_h [MAX_POINTS];
   logic        mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [31:0] rd_x_ff, rd_y_ff;
   logic [16:0] rd_h_ff;

   logic [1:0]  cmd_ff, cmd_in;
   logic        flag_ff, flag_in;
   logic [31:0] px_ff, px_in, py_ff, py_in, now_ff, now_in;
   logic [15:0] hd_ff, hd_in;

   // written from the captured beat, the bus has moved on by dispatch
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[mem_wa] <= px_ff;
         mem_y[mem_wa] <= py_ff;
         mem_h[mem_wa] <= {flag_ff, hd_ff};
      end
      rd_x_ff <= mem_x[mem_ra];
      rd_y_ff <= mem_y[mem_ra];
      rd_h_ff <= mem_h[mem_ra];
   end

   logic [3:0]  state_ff, state_in;
   logic [1:0]  pass_ff, pass_in;
   logic [CW-1:0] idx_ff, idx_in, count_ff, count_in;
   logic        started_ff, started_in, known_ff, known_in, rot_ff, rot_in;
   logic [31:0] start_ms_ff, start_ms_in;
   logic [15:0] target_ff, target_in;

   logic [31:0] prevx_ff, prevx_in, prevy_ff, prevy_in;
   logic [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [63:0] sq_ff, sq_in, acc_ff, acc_in;

   logic [2:0]  status_ff, status_in;
   logic [15:0] rate_ff, rate_in, err_ff, err_in;
   logic        has_ff, has_in;

   // shared 32x32 multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   assign mul_p = mul_a * mul_b;

   cordic_req_type creq;
   cordic_rsp_type crsp;

   hac_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .req(creq), .rsp(crsp));

   logic [32:0] adx, ady;
   logic        cfg_bad, tmo;
   logic [31:0] elapsed;
   logic [15:0] hi_t, lo_t;
   logic [16:0] emag_c;
   logic [47:0] prod_r;

   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      started_in = started_ff;
      known_in = known_ff;
      rot_in = rot_ff;
      start_ms_in = start_ms_ff;
      target_in = target_ff;
      cmd_in = cmd_ff;
      flag_in = flag_ff;
      px_in = px_ff;
      py_in = py_ff;
      now_in = now_ff;
      hd_in = hd_ff;
      prevx_in = prevx_ff;
      prevy_in = prevy_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      sq_in = sq_ff;
      acc_in = acc_ff;
      status_in = status_ff;
      rate_in = rate_ff;
      err_in = err_ff;
      has_in = has_ff;
      mem_we = 1'b0;
      mem_wa = count_ff[AW-1:0];
      mem_ra = idx_ff[AW-1:0];
      creq.start = 1'b0;
      creq.dx = dx_ff;
      creq.dy = dy_ff;
      mul_a = '0;
      mul_b = '0;
      adx = dx_ff[32] ? -dx_ff : dx_ff;
      ady = dy_ff[32] ? -dy_ff : dy_ff;
      cfg_bad = (hold_ff == 0) || (gain_ff == 0) || (rlim_ff == 0) || (mind_ff == 0);
      elapsed = now_ff - start_ms_ff;
      tmo = elapsed > hold_ff;
      hi_t = (enter_ff > exit_ff) ? enter_ff : exit_ff;
      lo_t = (enter_ff > exit_ff) ? exit_ff : enter_ff;
      emag_c = err_ff[15] ? (17'd65536 - {1'b0, err_ff}) : {1'b0, err_ff};
      prod_r = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser[1:0];
               flag_in = req_tuser[2];
               px_in = req_tdata[31:0];
               py_in = req_tdata[63:32];
               hd_in = req_tdata[79:64];
               now_in = req_tdata[111:80];
               rate_in = '0;
               err_in = '0;
               has_in = 1'b0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_OUT;
            case (cmd_ff)
               CMD_RESET_ALIGN: begin
                  started_in = 1'b0;
                  known_in = 1'b0;
                  rot_in = 1'b0;
                  start_ms_in = '0;
                  target_in = '0;
                  status_in = ST_STORED;
                  now_in = '0;
               end
               CMD_CLEAR_ROUTE: begin
                  count_in = '0;
                  status_in = ST_STORED;
                  now_in = '0;
               end
               CMD_APPEND: begin
                  if (32'(count_ff) < MAX_POINTS) begin
                     mem_we = 1'b1;
                     count_in = count_ff + 1'b1;
                     status_in = ST_STORED;
                  end else begin
                     status_in = ST_FULL;
                  end
                  now_in = '0;
               end
               default: begin
                  if (cfg_bad) begin
                     status_in = ST_BAD_CFG;
                  end else begin
                     if (!started_ff) begin
                        started_in = 1'b1;
                        start_ms_in = now_ff;
                     end
                     if (!known_ff) begin
                        pass_in = P_SEG;
                        idx_in = '0;
                        state_in = S_RD;
                     end else begin
                        state_in = S_CTRL;
                     end
                  end
               end
            endcase
         end
         S_RD: begin
            // end of a pass: move on
            if (pass_ff == P_SEG && 32'(idx_ff) >= 32'(count_ff)) begin
               pass_in = P_HDG;
               idx_in = '0;
            end else if (pass_ff == P_HDG && idx_ff >= count_ff) begin
               pass_in = P_ROB;
               idx_in = '0;
               if (!flag_ff) state_in = S_CTRL;
            end else if (pass_ff == P_ROB && idx_ff >= count_ff) begin
               status_in = ST_BAD_TASK;
               state_in = S_OUT;
            end else begin
               state_in = S_LAT;
            end
         end
         S_LAT: begin
            prevx_in = rd_x_ff;
            prevy_in = rd_y_ff;
            idx_in = idx_ff + 1'b1;
            state_in = S_RD;
            if (pass_ff == P_SEG) begin
               dx_in = 33'(signed'(rd_x_ff)) - 33'(signed'(prevx_ff));
               dy_in = 33'(signed'(rd_y_ff)) - 33'(signed'(prevy_ff));
               if (idx_ff != 0) state_in = S_CHK;
            end else if (pass_ff == P_HDG) begin
               if (rd_h_ff[16]) begin
                  target_in = rd_h_ff[15:0];
                  known_in = 1'b1;
                  state_in = S_CTRL;
               end
            end else begin
               dx_in = 33'(signed'(rd_x_ff)) - 33'(signed'(px_ff));
               dy_in = 33'(signed'(rd_y_ff)) - 33'(signed'(py_ff));
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (adx >= {2'b0, mind_ff} || ady >= {2'b0, mind_ff}) begin
               state_in = S_CORD;
            end else begin
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            mul_a = adx[31:0];
            mul_b = adx[31:0];
            acc_in = mul_p;
            state_in = S_SQY;
         end
         S_SQY: begin
            mul_a = ady[31:0];
            mul_b = ady[31:0];
            acc_in = acc_ff + mul_p;
            state_in = S_SQC;
         end
         S_SQC: begin
            mul_a = {1'b0, mind_ff};
            mul_b = {1'b0, mind_ff};
            state_in = (acc_ff >= mul_p) ? S_CORD : S_RD;
         end
         S_CORD: begin
            creq.start = 1'b1;
            state_in = S_CWAIT;
         end
         S_CWAIT: begin
            if (crsp.done) begin
               target_in = crsp.angle;
               known_in = 1'b1;
               state_in = S_CTRL;
            end
         end
         S_CTRL: begin
            state_in = S_OUT;
            if (!flag_ff) begin
               status_in = tmo ? ST_TIMED_OUT : ST_WAITING;
            end else begin
               has_in = 1'b1;
               err_in = target_ff - hd_ff;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_OUT;
            if (!rot_ff && emag_c <= {1'b0, hi_t}) begin
               status_in = ST_ALIGNED;
            end else begin
               rot_in = 1'b1;
               if (emag_c <= {1'b0, lo_t}) begin
                  status_in = ST_ALIGNED;
               end else begin
                  mul_a = {16'd0, gain_ff};
                  mul_b = {15'd0, emag_c};
                  sq_in = mul_p;
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            prod_r = (sq_ff[47:0] + 48'd128) >> 8;
            if (prod_r > {33'd0, rlim_ff}) prod_r = {33'd0, rlim_ff};
            rate_in = err_ff[15] ? -prod_r[15:0] : prod_r[15:0];
            status_in = ST_ALIGNING;
            if (tmo) begin
               status_in = ST_TIMED_OUT;
               rate_in = '0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         started_ff <= 1'b0;
         known_ff <= 1'b0;
         rot_ff <= 1'b0;
         start_ms_ff <= '0;
         target_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         started_ff <= started_in;
         known_ff <= known_in;
         rot_ff <= rot_in;
         start_ms_ff <= start_ms_in;
         target_ff <= target_in;
      end
      pass_ff <= pass_in;
      idx_ff <= idx_in;
      cmd_ff <= cmd_in;
      flag_ff <= flag_in;
      px_ff <= px_in;
      py_ff <= py_in;
      now_ff <= now_in;
      hd_ff <= hd_in;
      prevx_ff <= prevx_in;
      prevy_ff <= prevy_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      sq_ff <= sq_in;
      acc_ff <= acc_in;
      status_ff <= status_in;
      rate_ff <= rate_in;
      err_ff <= err_in;
      has_ff <= has_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {7'd0, now_ff, has_ff, (has_ff ? err_ff : 16'd0),
                        (has_ff ? target_ff : 16'd0), rate_ff};

   `HAC_ASSERT(a_count_cap, 32'(count_ff) <= MAX_POINTS, "route count overflow")
   `HAC_ASSERT(a_rate_cap, !(rsp_tvalid && status_ff != ST_ALIGNING && rate_ff != 16'd0), "rate outside aligning")
   `HAC_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(status_ff),
                    "response dropped")
endmodule

// ===== design/hac_cordic.sv =====
`timescale 1ns / 1ps
`include "heading_align_controller_defines.svh"
module hac_cordic
   import hac_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  cordic_req_type req,
   output cordic_rsp_type rsp
);
   localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

   localparam logic [1:0] C_IDLE  = 2'd0;
   localparam logic [1:0] C_NORM  = 2'd1;
   localparam logic [1:0] C_ROT   = 2'd2;
   localparam logic [1:0] C_DONE  = 2'd3;

   // 33-bit operands, small ones scaled up to ~2^30; rotation grows by <1.65: 35 bits fit, use 36
   logic [1:0]  state_ff, state_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic [31:0] z_ff, z_in;
   logic [4:0]  i_ff, i_in;
   logic [5:0]  n_ff, n_in;
   logic signed [35:0] xs, ys, ax, ay;

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      n_in = n_ff;
      ax = x_ff[35] ? -x_ff : x_ff;
      ay = y_ff[35] ? -y_ff : y_ff;
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      case (state_ff)
         C_IDLE: begin
            if (req.start) begin
               x_in = 36'(signed'(req.dx));
               y_in = 36'(signed'(req.dy));
               z_in = '0;
               n_in = '0;
               i_in = '0;
               state_in = C_NORM;
            end
         end
         C_NORM: begin
            if (ax < 36'sd1073741824 && ay < 36'sd1073741824 && n_ff < 6'd40) begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
               n_in = n_ff + 6'd1;
            end else begin
               if (x_ff[35]) begin
                  x_in = -x_ff;
                  y_in = -y_ff;
                  z_in = 32'h8000_0000;
               end
               state_in = C_ROT;
            end
         end
         C_ROT: begin
            if (!y_ff[35] && y_ff != 0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_entry(i_ff);
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_entry(i_ff);
            end
            i_in = i_ff + 5'd1;
            if (32'(i_ff) == NSTEPS - 1) state_in = C_DONE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         n_ff <= '0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      i_ff <= i_in;
   end

   logic [31:0] zr;
   assign zr = z_ff + 32'h0000_8000;
   assign rsp.done  = (state_ff == C_DONE);
   assign rsp.angle = zr[31:16];

   `HAC_ASSERT_NEXT(a_done_one, state_ff == C_DONE, state_ff == C_IDLE, "done held")
   `HAC_ASSERT(a_start_idle, !(req.start && state_ff != C_IDLE), "start while busy")
   `HAC_ASSERT(a_norm_cap, n_ff <= 6'd40, "normalize overrun")
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import hac_pkg::*;

   localparam int ROUTE_DEPTH = 64;
   localparam int CORDIC_ITERS = 16;
   localparam longint CYCLE_LIMIT = 10000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   heading_align_controller dut (.*);

   always #5 clock = ~clock;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] rate;
      logic [15:0] target;
      logic [15:0] err;
      logic        has_t;
      logic [31:0] stamp;
   } align_rsp_type;

   align_rsp_type rsp_q[$];
   int     errors = 0;
   longint cycles = 0;
   bit     sink_hold = 0;   // long receiver hold-off
   bit     no_idle = 0;

   // predictor state
   logic [31:0] enter_lvl, exit_lvl, hold_ms, gain, rate_max, min_len;
   logic signed [31:0] pt_x[ROUTE_DEPTH];
   logic signed [31:0] pt_y[ROUTE_DEPTH];
   logic [16:0] pt_h[ROUTE_DEPTH];
   int          n_pts;
   bit          started, tgt_known, rotating;
   logic [31:0] start_ms;
   logic [15:0] tgt;

   function automatic longint unsigned mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic bit far_enough(longint dx, longint dy);
      longint unsigned ax, ay, m;
      ax = mag(dx); ay = mag(dy); m = min_len;
      if (ax >= m || ay >= m) return 1;
      return ax * ax + ay * ay >= m * m;
   endfunction

   function automatic longint fshift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic logic [31:0] atan_lut(int i);
      case (i)
         0: return 32'd536870912;   1: return 32'd316933406;
         2: return 32'd167458907;   3: return 32'd85004756;
         4: return 32'd42667331;    5: return 32'd21354465;
         6: return 32'd10679838;    7: return 32'd5340245;
         8: return 32'd2670163;     9: return 32'd1335087;
         10: return 32'd667544;     11: return 32'd333772;
         12: return 32'd166886;     13: return 32'd83443;
         14: return 32'd41722;      15: return 32'd20861;
         default: return 32'd0;
      endcase
   endfunction

   function automatic logic [15:0] bearing(longint y, longint x);
      logic [31:0] z;
      longint xs, ys;
      int n;
      z = 0; n = 0;
      while (mag(x) < (64'd1 << 30) && mag(y) < (64'd1 << 30) && n < 40) begin
         x = x * 2; y = y * 2; n++;
      end
      if (x < 0) begin
         x = -x; y = -y; z = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         xs = fshift(x, i); ys = fshift(y, i);
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_lut(i);
         end else begin
            x = x - ys; y = y + xs; z = z - atan_lut(i);
         end
      end
      z = z + 32'h8000;
      return z[31:16];
   endfunction

   function automatic bit find_target(longint rx, longint ry, bit ok, output logic [15:0] t);
      t = 0;
      for (int i = 0; i + 1 < n_pts; i++)
         if (far_enough(longint'(pt_x[i+1]) - pt_x[i], longint'(pt_y[i+1]) - pt_y[i])) begin
            t = bearing(longint'(pt_y[i+1]) - pt_y[i], longint'(pt_x[i+1]) - pt_x[i]);
            return 1;
         end
      for (int i = 0; i < n_pts; i++)
         if (pt_h[i][16]) begin
            t = pt_h[i][15:0];
            return 1;
         end
      if (ok)
         for (int i = 0; i < n_pts; i++)
            if (far_enough(longint'(pt_x[i]) - rx, longint'(pt_y[i]) - ry)) begin
               t = bearing(longint'(pt_y[i]) - ry, longint'(pt_x[i]) - rx);
               return 1;
            end
      return 0;
   endfunction

   function automatic align_rsp_type predict_align(logic [1:0] cmd, logic signed [31:0] px,
         logic signed [31:0] py, logic [15:0] hd, bit flag, logic [31:0] now);
      align_rsp_type r;
      logic [15:0] t, e;
      logic [31:0] emag, hi, lo;
      longint unsigned p;
      bit decided;
      r = '0;
      decided = 0;
      case (cmd)
         CMD_RESET_ALIGN: begin
            started = 0; tgt_known = 0; rotating = 0; start_ms = 0; tgt = 0;
            r.status = ST_STORED;
         end
         CMD_CLEAR_ROUTE: begin
            n_pts = 0;
            r.status = ST_STORED;
         end
         CMD_APPEND: begin
            if (n_pts < ROUTE_DEPTH) begin
               pt_x[n_pts] = px; pt_y[n_pts] = py; pt_h[n_pts] = {flag, hd};
               n_pts++;
               r.status = ST_STORED;
            end else r.status = ST_FULL;
         end
         default: begin
            r.stamp = now;
            if (hold_ms == 0 || gain == 0 || rate_max == 0 || min_len == 0) begin
               r.status = ST_BAD_CFG;
               return r;
            end
            if (!started) begin
               started = 1; start_ms = now;
            end
            if (!tgt_known) begin
               if (find_target(px, py, flag, t)) begin
                  tgt = t; tgt_known = 1;
               end else if (flag) begin
                  r.status = ST_BAD_TASK; decided = 1;
               end
            end
            if (!decided && !flag) begin
               r.status = (now - start_ms > hold_ms) ? ST_TIMED_OUT : ST_WAITING;
               decided = 1;
            end
            if (!decided) begin
               r.has_t = 1;
               e = tgt - hd;
               r.target = tgt; r.err = e;
               emag = e[15] ? 32'd65536 - e : e;
               hi = enter_lvl > exit_lvl ? enter_lvl : exit_lvl;
               lo = enter_lvl > exit_lvl ? exit_lvl : enter_lvl;
               if (!rotating && emag <= hi) r.status = ST_ALIGNED;
               else begin
                  rotating = 1;
                  if (emag <= lo) r.status = ST_ALIGNED;
                  else begin
                     p = (longint'(gain) * emag + 128) >> 8;
                     if (p > rate_max) p = rate_max;
                     r.rate = e[15] ? -16'(p) : 16'(p);
                     r.status = ST_ALIGNING;
                     if (now - start_ms > hold_ms) begin
                        r.status = ST_TIMED_OUT; r.rate = 0;
                     end
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   task automatic send_item(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
         logic [15:0] hd, bit flag, logic [31:0] now);
      while (!no_idle && $urandom_range(99) < 10) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {now, hd, py, px};
      req_tuser <= {flag, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rsp_q.push_back(predict_align(cmd, px, py, hd, flag, now));
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_ENTER: enter_lvl = v[15:0];
         REG_EXIT:  exit_lvl = v[15:0];
         REG_HOLD:  hold_ms = v;
         REG_GAIN:  gain = v[15:0];
         REG_RATE:  rate_max = v[14:0];
         REG_MIND:  min_len = v[30:0];
         default: ;
      endcase
   endtask

   task automatic tick(logic [31:0] px, logic [31:0] py, logic [15:0] yaw, bit ok,
         logic [31:0] now);
      send_item(CMD_TICK, px, py, yaw, ok, now);
   endtask

   task automatic test_commands();
      send_item(CMD_TICK, 0, 0, 0, 1, 0);                   // no route: invalid task
      send_item(CMD_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 1, '1);
      send_item(CMD_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 0, 0);
      tick(0, 0, 16'h8000, 1, 0);
      tick(0, 0, 16'h0, 1, 32'hFFFF_FFFF);                   // long elapsed
      tick(0, 0, 16'h1234, 0, 10);                           // waiting
      send_item(CMD_RESET_ALIGN, 0, 0, 0, 0, 0);
      send_item(CMD_CLEAR_ROUTE, 0, 0, 0, 0, 0);
      send_item(CMD_APPEND, 5, 5, 16'h4000, 1, 0);           // explicit heading only
      tick(0, 0, 16'hC000, 1, 100);
      tick(0, 0, 16'h3F00, 1, 200);
      send_item(CMD_RESET_ALIGN, 0, 0, 0, 0, 0);
      send_item(CMD_CLEAR_ROUTE, 0, 0, 0, 0, 0);
      send_item(CMD_APPEND, 1000, -2000, 0, 0, 0);           // direction from robot
      tick(0, 0, 0, 1, 5);
      tick(0, 0, 0, 1, 6000);                                // aligning timeout
      send_item(CMD_CLEAR_ROUTE, 0, 0, 0, 0, 0);
      for (int i = 0; i < ROUTE_DEPTH + 1; i++)              // last one is full
         send_item(CMD_APPEND, i, -i, 16'(i), 0, 0);
      send_item(CMD_RESET_ALIGN, 0, 0, 0, 0, 0);
      tick(32'd100, 0, 0, 1, 1);
      drain();
   endtask

   task automatic test_config_edges();
      write_reg(REG_HOLD, 0);
      tick(0, 0, 0, 1, 0);
      drain();
      write_reg(REG_HOLD, 32'hFFFF_FFFF);
      write_reg(REG_GAIN, 0);
      tick(0, 0, 0, 1, 0);
      drain();
      write_reg(REG_GAIN, 16'hFFFF);
      write_reg(REG_RATE, 0);
      tick(0, 0, 0, 1, 0);
      drain();
      write_reg(REG_RATE, 15'h7FFF);
      write_reg(REG_MIND, 0);
      tick(0, 0, 0, 1, 0);
      drain();
      write_reg(REG_MIND, 32'h7FFF_FFFF);
      write_reg(REG_ENTER, 0);
      write_reg(REG_EXIT, 32768);
      send_item(CMD_RESET_ALIGN, 0, 0, 0, 0, 0);
      tick(32'h8000_0000, 32'h8000_0000, 16'h1000, 1, 0);
      tick(0, 0, 16'h8000, 1, 1);
      drain();
   endtask

   task automatic random_phase(int n_items);
      logic [31:0] now, span, rx, ry;
      int sel;
      now = $urandom;
      span = $urandom_range(3) == 0 ? $urandom : $urandom_range(5000);
      for (int k = 0; k < n_items; k++) begin
         sel = $urandom_range(99);
         rx = $urandom_range(1) ? $urandom : $urandom_range(4000) - 2000;
         ry = $urandom_range(1) ? $urandom : $urandom_range(4000) - 2000;
         if (sel < 4)
            send_item(CMD_RESET_ALIGN, rx, ry, 16'($urandom), 1'($urandom), $urandom);
         else if (sel < 7)
            send_item(CMD_CLEAR_ROUTE, rx, ry, 16'($urandom), 1'($urandom), $urandom);
         else if (sel < 30)
            send_item(CMD_APPEND, rx, ry, 16'($urandom), $urandom_range(3) == 0, $urandom);
         else begin
            now = now + ($urandom_range(19) == 0 ? $urandom : $urandom_range(span));
            tick(rx, ry, 16'($urandom), $urandom_range(7) != 0, now);
         end
      end
      drain();
   endtask

   task automatic random_config();
      int pick;
      pick = $urandom_range(3);
      write_reg(REG_ENTER, pick == 0 ? 0 : pick == 1 ? 32768 : $urandom_range(32768));
      write_reg(REG_EXIT, $urandom_range(1) ? $urandom_range(32768) : $urandom_range(2000));
      write_reg(REG_HOLD, $urandom_range(15) == 0 ? 0 : $urandom_range(6000) + 1);
      write_reg(REG_GAIN, $urandom_range(15) == 0 ? 0 : $urandom_range(65535));
      write_reg(REG_RATE, $urandom_range(15) == 0 ? 0 : $urandom_range(32767));
      write_reg(REG_MIND, pick == 3 ? 32'h7FFF_FFFF : $urandom_range(15) == 0 ? 0 :
                $urandom_range(3000) + 1);
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 14; ph++) begin
         random_config();
         no_idle = (ph == 5);
         random_phase(110);
      end
      no_idle = 0;
   endtask

   task automatic test_backpressure();
      sink_hold = 1;
      for (int k = 0; k < 6; k++)
         send_item(CMD_APPEND, $urandom, $urandom, 16'($urandom), 1, 0);
      wait (sink_hold == 0);
      drain();
   endtask

   // receiver
   always @(posedge clock) begin
      if (sink_hold) rsp_tready <= 1'b0;
      else rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 10);
   end

   initial begin
      wait (sink_hold == 1);
      repeat (400) @(posedge clock);
      sink_hold = 0;
   end

   always @(posedge clock) begin
      align_rsp_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                rsp_tdata[48], rsp_tdata[80:49]};
         if (rsp_q.size() == 0) begin
            $display("%0t unexpected beat: actual %p", $time, got);
            errors++;
         end else begin
            want = rsp_q.pop_front();
            if (got.status !== want.status || got.rate !== want.rate ||
                got.target !== want.target || got.err !== want.err ||
                got.has_t !== want.has_t || got.stamp !== want.stamp) begin
               $display("%0t mismatch: expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      enter_lvl = 910; exit_lvl = 364; hold_ms = 5000; gain = 512; rate_max = 4096;
      min_len = 100; n_pts = 0; started = 0; tgt_known = 0; rotating = 0;
      start_ms = 0; tgt = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_commands();
      test_config_edges();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0 && rsp_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/hac_pkg.sv
design/hac_cordic.sv
design/heading_align_controller.sv
verif/tb.sv
